@@ src/scoped_symbol_stack_macros.svh @@
`ifndef SCOPED_SYMBOL_STACK_MACROS_SVH
`define SCOPED_SYMBOL_STACK_MACROS_SVH

// Both macros expect clk and arst_n in the scope where they are used.

`define SSYM_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define SSYM_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/ssym_pkg.sv @@
package ssym_pkg;

	localparam int SSYM_DEPTH = 256;
	localparam int SSYM_KEY_W = 32;
	localparam int KEY_MAX_W = 64;

	localparam int CMD_W = 3;
	localparam int KEY_PORT_W = 32;
	localparam int ADDR_W = 16;
	localparam int SIZE_W = 16;
	localparam int LEVEL_W = 8;
	localparam int DEPTH_OUT_W = 9;
	localparam int STATUS_W = 2;
	localparam int PAYLOAD_W = ADDR_W + SIZE_W + LEVEL_W;

	localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK = 3'd2;
	localparam logic [CMD_W-1:0] CMD_UNWIND = 3'd3;
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic found;
		logic [KEY_PORT_W-1:0] key_out;
		logic [ADDR_W-1:0] addr_out;
		logic [SIZE_W-1:0] size_out;
		logic [LEVEL_W-1:0] level_out;
		logic [DEPTH_OUT_W-1:0] depth;
		logic [STATUS_W-1:0] status;
	} res_t;

endpackage

@@ src/ssym_if.sv @@
interface ssym_req_if import ssym_pkg::*; ();
	logic valid;
	logic ready;
	logic [CMD_W-1:0] cmd;
	logic [KEY_PORT_W-1:0] key;
	logic [ADDR_W-1:0] addr_in;
	logic [SIZE_W-1:0] size_in;
	logic [LEVEL_W-1:0] level;

	modport source (output valid, cmd, key, addr_in, size_in, level, input ready);
	modport sink (input valid, cmd, key, addr_in, size_in, level, output ready);
endinterface

interface ssym_rsp_if import ssym_pkg::*; ();
	logic valid;
	logic ready;
	logic found;
	logic [KEY_PORT_W-1:0] key_out;
	logic [ADDR_W-1:0] addr_out;
	logic [SIZE_W-1:0] size_out;
	logic [LEVEL_W-1:0] level_out;
	logic [DEPTH_OUT_W-1:0] depth;
	logic [STATUS_W-1:0] status;

	modport source (output valid, found, key_out, addr_out, size_out, level_out, depth, status,
		input ready);
	modport sink (input valid, found, key_out, addr_out, size_out, level_out, depth, status,
		output ready);
endinterface

@@ src/ssym_ram.sv @@
module ssym_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/ssym_seq.sv @@
`include "scoped_symbol_stack_macros.svh"

module ssym_seq import ssym_pkg::*; #(
	parameter int DEPTH = SSYM_DEPTH,
	parameter int KEY_WIDTH = SSYM_KEY_W,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1),
	localparam int WORD_W = KEY_WIDTH + PAYLOAD_W
) (
	input logic clk,
	input logic arst_n,
	ssym_req_if.sink cmd_ch,
	output res_t res,
	output logic res_valid,
	input logic res_free,
	output logic ram_we,
	output logic [AW-1:0] ram_waddr,
	output logic [WORD_W-1:0] ram_wdata,
	output logic [AW-1:0] ram_raddr,
	input logic [WORD_W-1:0] ram_rdata
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_UNW = 3'd2;
	localparam logic [2:0] S_LKP = 3'd3;
	localparam logic [2:0] S_FIN = 3'd4;

	logic [2:0] state_q, state_d;
	logic [CW-1:0] fill_q, fill_d, fill_m1;
	logic [AW-1:0] scan_q, scan_d;
	logic [KEY_WIDTH-1:0] key_q, key_st, rd_key;
	logic [LEVEL_W-1:0] lvl_q, rd_level;
	logic [ADDR_W-1:0] rd_addr;
	logic [SIZE_W-1:0] rd_size;
	logic [KEY_MAX_W-1:0] key64, kout64;
	res_t res_q, res_d, hit;
	logic acc, full, empty;

	assign cmd_ch.ready = (state_q == S_IDLE);
	assign acc = cmd_ch.valid && cmd_ch.ready;
	assign full = (fill_q == CW'(DEPTH));
	assign empty = (fill_q == '0);
	assign fill_m1 = fill_q - 1'b1;

	assign key64 = {{(KEY_MAX_W - KEY_PORT_W){1'b0}}, cmd_ch.key};
	assign key_st = key64[KEY_WIDTH-1:0];

	assign ram_we = acc && (cmd_ch.cmd == CMD_PUSH) && !full;
	assign ram_waddr = fill_q[AW-1:0];
	assign ram_wdata = {key_st, cmd_ch.addr_in, cmd_ch.size_in, cmd_ch.level};
	assign ram_raddr = (state_q == S_IDLE) ? fill_m1[AW-1:0] : scan_q - 1'b1;

	assign rd_level = ram_rdata[LEVEL_W-1:0];
	assign rd_size = ram_rdata[LEVEL_W +: SIZE_W];
	assign rd_addr = ram_rdata[LEVEL_W + SIZE_W +: ADDR_W];
	assign rd_key = ram_rdata[PAYLOAD_W +: KEY_WIDTH];

	always_comb begin
		kout64 = '0;
		kout64[KEY_WIDTH-1:0] = rd_key;
		hit = '0;
		hit.found = 1'b1;
		hit.key_out = kout64[KEY_PORT_W-1:0];
		hit.addr_out = rd_addr;
		hit.size_out = rd_size;
		hit.level_out = rd_level;
		hit.status = ST_OK;
	end

	always_comb begin
		state_d = state_q;
		fill_d = fill_q;
		scan_d = scan_q;
		res_d = res_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					res_d = '0;
					res_d.status = ST_OK;
					scan_d = fill_m1[AW-1:0];
					state_d = S_FIN;
					unique case (cmd_ch.cmd)
						CMD_PUSH: begin
							if (full) begin
								res_d.status = ST_FULL;
							end else begin
								fill_d = fill_q + 1'b1;
							end
						end
						CMD_POP: begin
							if (empty) begin
								res_d.status = ST_EMPTY;
							end else begin
								fill_d = fill_m1;
								state_d = S_READ;
							end
						end
						CMD_PEEK: begin
							if (!empty) begin
								state_d = S_READ;
							end
						end
						CMD_UNWIND: begin
							if (!empty) begin
								state_d = S_UNW;
							end
						end
						CMD_LOOKUP: begin
							if (!empty) begin
								state_d = S_LKP;
							end
						end
						default: state_d = S_FIN;
					endcase
				end
			end
			S_READ: begin
				res_d = hit;
				state_d = S_FIN;
			end
			S_UNW: begin
				if (rd_level > lvl_q) begin
					fill_d = fill_m1;
					scan_d = scan_q - 1'b1;
					if (scan_q == '0) begin
						state_d = S_FIN;
					end
				end else begin
					state_d = S_FIN;
				end
			end
			S_LKP: begin
				if (rd_key == key_q) begin
					res_d = hit;
					state_d = S_FIN;
				end else if (scan_q == '0) begin
					state_d = S_FIN;
				end else begin
					scan_d = scan_q - 1'b1;
				end
			end
			S_FIN: begin
				if (res_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
		end else begin
			state_q <= state_d;
			fill_q <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		scan_q <= scan_d;
		res_q <= res_d;
		if (acc) begin
			key_q <= key_st;
			lvl_q <= cmd_ch.level;
		end
	end

	always_comb begin
		res = res_q;
		res.depth = DEPTH_OUT_W'(fill_q);
	end
	assign res_valid = (state_q == S_FIN);

	`SSYM_ASSERT_IMPL(a_fill_bound, 1'b1, fill_q <= CW'(DEPTH), "fill count above depth")
	`SSYM_ASSERT_IMPL(a_unw_top, state_q == S_UNW, CW'(scan_q) + 1'b1 == fill_q, "unwind not at top")
	`SSYM_ASSERT_IMPL(a_lkp_range, state_q == S_LKP, CW'(scan_q) < fill_q, "lookup beyond top")
	`SSYM_ASSERT_NEXT(a_push_grow, ram_we, fill_q == $past(fill_q) + 1'b1, "push did not grow stack")

endmodule

@@ src/ssym_outreg.sv @@
module ssym_outreg import ssym_pkg::*; (
	input logic clk,
	input logic arst_n,
	input res_t res,
	input logic res_valid,
	output logic res_free,
	ssym_rsp_if.source rsp_ch
);

	logic valid_q;
	res_t data_q;

	assign res_free = !valid_q || rsp_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_free) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && res_valid) begin
			data_q <= res;
		end
	end

	assign rsp_ch.valid = valid_q;
	assign rsp_ch.found = data_q.found;
	assign rsp_ch.key_out = data_q.key_out;
	assign rsp_ch.addr_out = data_q.addr_out;
	assign rsp_ch.size_out = data_q.size_out;
	assign rsp_ch.level_out = data_q.level_out;
	assign rsp_ch.depth = data_q.depth;
	assign rsp_ch.status = data_q.status;

endmodule

@@ src/scoped_symbol_stack.sv @@
// Scoped symbol stack: a last-in first-out store of up to DEPTH symbols, each with a key,
// address, byte size and scope level, held in one single-port-write, registered-read RAM.
// A request carries push, pop, peek, unwind or lookup and returns exactly one response with
// the stack depth after the request and a status (pop on an empty stack and push on a full
// stack are flagged; a full push is dropped). Requests are handled one at a time. A pop
// or peek on a non-empty stack waits on one read of the RAM, and unwind or lookup visit
// entries from the top, one entry per step, every step waiting on one read of the RAM.
// The response sits in an output register, so the next request is taken while an
// earlier response waits.
// No clearing pass is needed after reset.
module scoped_symbol_stack import ssym_pkg::*; #(
	parameter int DEPTH = SSYM_DEPTH,
	parameter int KEY_WIDTH = SSYM_KEY_W
) (
	input logic clk,
	input logic arst_n,
	ssym_req_if.sink cmd_ch,
	ssym_rsp_if.source rsp_ch
);

	localparam int AW = $clog2(DEPTH);
	localparam int WORD_W = KEY_WIDTH + PAYLOAD_W;

	res_t res;
	logic res_valid;
	logic res_free;
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;

	ssym_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	ssym_seq #(
		.DEPTH(DEPTH),
		.KEY_WIDTH(KEY_WIDTH)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_ch(cmd_ch),
		.res(res),
		.res_valid(res_valid),
		.res_free(res_free),
		.ram_we(ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	ssym_outreg u_outreg (
		.clk(clk),
		.arst_n(arst_n),
		.res(res),
		.res_valid(res_valid),
		.res_free(res_free),
		.rsp_ch(rsp_ch)
	);

endmodule

@@ tb/scoped_symbol_stack_test.sv @@
`timescale 1ns / 1ps

module scoped_symbol_stack_test;
	import ssym_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;
	localparam int POOL_SIZE = 24;

	logic clk = 1'b0;
	logic arst_n;

	ssym_req_if req_bus ();
	ssym_rsp_if rsp_bus ();

	scoped_symbol_stack DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_ch(req_bus),
		.rsp_ch(rsp_bus)
	);

	logic [KEY_PORT_W-1:0] sym_key [SSYM_DEPTH];
	logic [ADDR_W-1:0] sym_addr [SSYM_DEPTH];
	logic [SIZE_W-1:0] sym_size [SSYM_DEPTH];
	logic [LEVEL_W-1:0] sym_level [SSYM_DEPTH];
	int stack_fill = 0;

	res_t expected_results[$];
	res_t want;
	int mismatch_count = 0;
	int hold_cycles = 0;
	bit steady = 1'b0;
	logic [KEY_PORT_W-1:0] key_pool [POOL_SIZE];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic res_t stack_entry(input int slot);
		res_t o;
		o = '0;
		o.found = 1'b1;
		o.key_out = sym_key[slot];
		o.addr_out = sym_addr[slot];
		o.size_out = sym_size[slot];
		o.level_out = sym_level[slot];
		return o;
	endfunction

	function automatic res_t predict_symbol_op(input logic [CMD_W-1:0] cmd,
			input logic [KEY_PORT_W-1:0] key, input logic [ADDR_W-1:0] addr,
			input logic [SIZE_W-1:0] size, input logic [LEVEL_W-1:0] level);
		res_t o;
		int i;
		o = '0;
		case (cmd)
			CMD_PUSH: begin
				if (stack_fill >= SSYM_DEPTH) begin
					o.status = ST_FULL;
				end else begin
					sym_key[stack_fill] = key;
					sym_addr[stack_fill] = addr;
					sym_size[stack_fill] = size;
					sym_level[stack_fill] = level;
					stack_fill++;
				end
			end
			CMD_POP: begin
				if (stack_fill == 0) begin
					o.status = ST_EMPTY;
				end else begin
					stack_fill--;
					o = stack_entry(stack_fill);
				end
			end
			CMD_PEEK: begin
				if (stack_fill > 0)
					o = stack_entry(stack_fill - 1);
			end
			CMD_UNWIND: begin
				while (stack_fill > 0 && sym_level[stack_fill - 1] > level)
					stack_fill--;
			end
			CMD_LOOKUP: begin
				for (i = stack_fill - 1; i >= 0 && !o.found; i--) begin
					if (sym_key[i] == key)
						o = stack_entry(i);
				end
			end
			default: begin
			end
		endcase
		o.depth = stack_fill[DEPTH_OUT_W-1:0];
		return o;
	endfunction

	task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [KEY_PORT_W-1:0] key,
			input logic [ADDR_W-1:0] addr, input logic [SIZE_W-1:0] size,
			input logic [LEVEL_W-1:0] level);
		@(negedge clk);
		if (!steady) begin
			while ($urandom_range(0, 99) < 14) begin
				req_bus.valid = 1'b0;
				@(negedge clk);
			end
		end
		req_bus.valid = 1'b1;
		req_bus.cmd = cmd;
		req_bus.key = key;
		req_bus.addr_in = addr;
		req_bus.size_in = size;
		req_bus.level = level;
		do
			@(posedge clk);
		while (!req_bus.ready);
		expected_results.push_back(predict_symbol_op(cmd, key, addr, size, level));
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		req_bus.valid = 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			rsp_bus.ready = 1'b0;
			hold_cycles--;
		end else begin
			rsp_bus.ready = steady || ($urandom_range(0, 99) >= 14);
		end
	end

	task automatic check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, exp_val,
					act_val);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: response arrived with no request outstanding", $realtime);
			end else begin
				want = expected_results.pop_front();
				check_field("found", 32'(want.found), 32'(rsp_bus.found));
				check_field("key_out", want.key_out, rsp_bus.key_out);
				check_field("addr_out", 32'(want.addr_out), 32'(rsp_bus.addr_out));
				check_field("size_out", 32'(want.size_out), 32'(rsp_bus.size_out));
				check_field("level_out", 32'(want.level_out), 32'(rsp_bus.level_out));
				check_field("depth", 32'(want.depth), 32'(rsp_bus.depth));
				check_field("status", 32'(want.status), 32'(rsp_bus.status));
			end
		end
	end

	task automatic test_empty_stack();
		send_request(CMD_PEEK, '0, '0, '0, '0);
		send_request(CMD_POP, '0, '0, '0, '0);
		send_request(CMD_UNWIND, '0, '0, '0, '0);
		send_request(CMD_LOOKUP, '0, '0, '0, '0);
		send_request(CMD_SPARE_A, '1, '1, '1, '1);
		send_request(CMD_SPARE_B, '0, '0, '0, '0);
		send_request(CMD_SPARE_C, '1, '1, '1, '1);
	endtask

	task automatic test_basic_ops();
		send_request(CMD_PUSH, '0, '0, '0, '0);
		send_request(CMD_PUSH, '1, '1, '1, '1);
		send_request(CMD_PUSH, 32'h1234_5678, 16'h00ff, 16'hff00, 8'd1);
		send_request(CMD_PUSH, 32'h1234_5678, 16'ha5a5, 16'h5a5a, 8'd2);
		send_request(CMD_PEEK, '0, '0, '0, '0);
		send_request(CMD_LOOKUP, 32'h1234_5678, '0, '0, '0);
		send_request(CMD_LOOKUP, '1, '0, '0, '0);
		send_request(CMD_LOOKUP, '0, '0, '0, '0);
		send_request(CMD_LOOKUP, 32'hdead_beef, '0, '0, '0);
		send_request(CMD_UNWIND, '0, '0, '0, 8'd255);
		send_request(CMD_UNWIND, '0, '0, '0, 8'd1);
		send_request(CMD_POP, '0, '0, '0, '0);
		send_request(CMD_POP, '0, '0, '0, '0);
		send_request(CMD_UNWIND, '0, '0, '0, '0);
		send_request(CMD_POP, '0, '0, '0, '0);
		send_request(CMD_POP, '0, '0, '0, '0);
	endtask

	task automatic test_full_stack();
		int i;
		logic [KEY_PORT_W-1:0] bottom_key;
		steady = 1'b1;
		bottom_key = $urandom;
		for (i = 0; i < SSYM_DEPTH; i++)
			send_request(CMD_PUSH, (i == 0) ? bottom_key : $urandom, ADDR_W'($urandom),
				SIZE_W'($urandom), LEVEL_W'(i / 32));
		send_request(CMD_PUSH, $urandom, ADDR_W'($urandom), SIZE_W'($urandom), '0);
		send_request(CMD_PUSH, '1, '1, '1, '1);
		send_request(CMD_PEEK, '0, '0, '0, '0);
		send_request(CMD_LOOKUP, bottom_key, '0, '0, '0);
		send_request(CMD_LOOKUP, ~bottom_key, '0, '0, '0);
		send_request(CMD_UNWIND, '0, '0, '0, 8'd7);
		send_request(CMD_UNWIND, '0, '0, '0, 8'd3);
		send_request(CMD_UNWIND, '0, '0, '0, 8'd0);
		send_request(CMD_PEEK, '0, '0, '0, '0);
		wait_for_results();
		steady = 1'b0;
	endtask

	task automatic test_backpressure();
		int i;
		hold_cycles = 150;
		for (i = 0; i < 12; i++) begin
			if (i % 3 == 0)
				send_request(CMD_PUSH, $urandom, ADDR_W'($urandom), SIZE_W'($urandom), 8'd1);
			else if (i % 3 == 1)
				send_request(CMD_LOOKUP, sym_key[0], '0, '0, '0);
			else
				send_request(CMD_PEEK, '0, '0, '0, '0);
		end
		wait_for_results();
		send_request(CMD_POP, '0, '0, '0, '0);
		send_request(CMD_UNWIND, '0, '0, '0, '0);
	endtask

	task automatic test_random_scopes(input int count);
		int n;
		int pick;
		int scope_now;
		logic [KEY_PORT_W-1:0] k;
		logic [LEVEL_W-1:0] lv;
		logic [CMD_W-1:0] c;
		scope_now = 0;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (n = 2; n < POOL_SIZE; n++)
			key_pool[n] = $urandom;
		for (n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick >= 8 && pick < 45 && stack_fill >= 200 && $urandom_range(0, 3) != 0)
				pick = 60;
			k = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom;
			if (pick < 3) begin
				case ($urandom_range(0, 2))
					0: c = CMD_SPARE_A;
					1: c = CMD_SPARE_B;
					default: c = CMD_SPARE_C;
				endcase
				send_request(c, $urandom, ADDR_W'($urandom), SIZE_W'($urandom),
					LEVEL_W'($urandom));
			end else if (pick < 8) begin
				c = CMD_W'($urandom_range(CMD_PUSH, CMD_SPARE_C));
				send_request(c, $urandom, ADDR_W'($urandom), SIZE_W'($urandom),
					LEVEL_W'($urandom));
			end else if (pick < 45) begin
				if (pick < 15 && scope_now < 255)
					scope_now++;
				lv = (pick < 10) ? LEVEL_W'($urandom) : LEVEL_W'(scope_now);
				send_request(CMD_PUSH, k, ADDR_W'($urandom), SIZE_W'($urandom), lv);
			end else if (pick < 55) begin
				scope_now = scope_now - int'($urandom_range(0, 2));
				if (scope_now < 0)
					scope_now = 0;
				lv = (pick < 47) ? LEVEL_W'($urandom) : LEVEL_W'(scope_now);
				send_request(CMD_UNWIND, $urandom, ADDR_W'($urandom), SIZE_W'($urandom), lv);
			end else if (pick < 67) begin
				send_request(CMD_POP, $urandom, ADDR_W'($urandom), SIZE_W'($urandom),
					LEVEL_W'($urandom));
			end else if (pick < 75) begin
				send_request(CMD_PEEK, $urandom, ADDR_W'($urandom), SIZE_W'($urandom),
					LEVEL_W'($urandom));
			end else begin
				send_request(CMD_LOOKUP, k, ADDR_W'($urandom), SIZE_W'($urandom),
					LEVEL_W'($urandom));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.cmd = CMD_PUSH;
		req_bus.key = '0;
		req_bus.addr_in = '0;
		req_bus.size_in = '0;
		req_bus.level = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_stack();
		test_basic_ops();
		test_full_stack();
		test_backpressure();
		test_random_scopes(900);

		wait_for_results();
		repeat (300) @(posedge clk);
		if (mismatch_count == 0)
			$display("scoped_symbol_stack_test passed");
		else
			$display("scoped_symbol_stack_test failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("scoped_symbol_stack_test failed");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+src
src/ssym_pkg.sv
src/ssym_if.sv
src/ssym_ram.sv
src/ssym_seq.sv
src/ssym_outreg.sv
src/scoped_symbol_stack.sv
tb/scoped_symbol_stack_test.sv
